// ===== rtl/sukt_pkg.sv =====
// ----------------------------------------------------------------------------
// sukt_pkg
// Shared types and codes for the sorted unique key table.
// ----------------------------------------------------------------------------
`default_nettype none

package sukt_pkg;

    localparam int KEY_W    = 32;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_DELETE = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_DUPLICATE = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } state_t;

    typedef struct packed {
        logic cmp;
        logic ins;
        logic del;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/sorted_unique_key_table_core.sv =====
// ----------------------------------------------------------------------------
// sorted_unique_key_table_core
// Ascending table of unique signed keys in a row of cells, with insert,
// search and delete.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  in       in_valid / in_stall   opcode, key
//  out      out_valid / out_stall status, found, removed_value, entry_count
//
//  One request at a time, taken only in idle: a compare state in which every
//  cell compares, then an update state in which the cells from the key's slot on
//  shift on insert or delete and which waits while a previous result is stalled.
//  Reset clears the count and control; keys are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_unique_key_table_core #(
    parameter int CAPACITY = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [sukt_pkg::OP_W-1:0]            opcode,
    input  wire logic signed [sukt_pkg::KEY_W-1:0]    key,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [sukt_pkg::STATUS_W-1:0]             status,
    output logic                                      found,
    output logic signed [sukt_pkg::KEY_W-1:0]         removed_value,
    output logic [sukt_pkg::COUNT_W-1:0]              entry_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    sukt_pkg::state_t state_reg, state_next;
    sukt_pkg::op_t    op_reg;
    logic signed [sukt_pkg::KEY_W-1:0] probe_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    logic                              out_valid_reg;
    logic [sukt_pkg::STATUS_W-1:0]     status_reg, status_next;
    logic                              found_reg, found_next;
    logic signed [sukt_pkg::KEY_W-1:0] removed_reg, removed_next;
    logic [sukt_pkg::COUNT_W-1:0]      entry_reg, entry_next;

    logic                 in_xfer;
    logic                 upd_go;
    logic                 hit;
    logic                 full;
    sukt_pkg::cell_ctrl_t ctrl;
    logic [CNT_W+sukt_pkg::COUNT_W-1:0] count_wide;

    logic signed [sukt_pkg::KEY_W-1:0] cell_key [CAPACITY];
    logic [CAPACITY-1:0]               cell_lt;
    logic [CAPACITY-1:0]               cell_eq;

    assign in_xfer = in_valid && !in_stall;
    assign hit     = |cell_eq;
    assign full    = (count_reg >= CNT_W'(CAPACITY));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sukt_pkg::S_IDLE: if (in_xfer) state_next = sukt_pkg::S_CMP;
            sukt_pkg::S_CMP:  state_next = sukt_pkg::S_UPD;
            sukt_pkg::S_UPD:  if (!out_valid_reg || !out_stall) state_next = sukt_pkg::S_IDLE;
            default:          state_next = sukt_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        in_stall = (state_reg != sukt_pkg::S_IDLE);
        upd_go   = (state_reg == sukt_pkg::S_UPD) && (!out_valid_reg || !out_stall);
        ctrl.cmp = (state_reg == sukt_pkg::S_CMP);
        ctrl.ins = upd_go && (op_reg == sukt_pkg::OP_INSERT) && !hit && !full;
        ctrl.del = upd_go && (op_reg == sukt_pkg::OP_DELETE) && hit;
    end

    always_comb
    begin
        count_next   = count_reg;
        status_next  = sukt_pkg::ST_DONE;
        found_next   = 1'b0;
        removed_next = '0;
        unique case (op_reg)
            sukt_pkg::OP_INSERT:
            begin
                found_next = hit;
                if (hit)
                begin
                    status_next = sukt_pkg::ST_DUPLICATE;
                end
                else if (full)
                begin
                    status_next = sukt_pkg::ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            sukt_pkg::OP_SEARCH:
            begin
                found_next  = hit;
                status_next = hit ? sukt_pkg::ST_DONE : sukt_pkg::ST_NOT_FOUND;
            end
            sukt_pkg::OP_DELETE:
            begin
                found_next = hit;
                if (hit)
                begin
                    removed_next = probe_reg;
                    count_next   = count_reg - CNT_W'(1);
                end
                else
                begin
                    status_next = sukt_pkg::ST_NOT_FOUND;
                end
            end
            default:
            begin
            end
        endcase
        count_wide = {{sukt_pkg::COUNT_W{1'b0}}, count_next};
        entry_next = count_wide[sukt_pkg::COUNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sukt_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (upd_go)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg    <= sukt_pkg::op_t'(opcode);
            probe_reg <= key;
        end
        if (upd_go)
        begin
            status_reg  <= status_next;
            found_reg   <= found_next;
            removed_reg <= removed_next;
            entry_reg   <= entry_next;
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                              left_lt;
        logic signed [sukt_pkg::KEY_W-1:0] left_key;
        logic signed [sukt_pkg::KEY_W-1:0] right_key;
        logic                              valid;

        if (i == 0)
        begin : g_first
            assign left_lt  = 1'b1;
            assign left_key = probe_reg;
        end
        else
        begin : g_mid
            assign left_lt  = cell_lt[i-1];
            assign left_key = cell_key[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_key = '0;
        end
        else
        begin : g_inner
            assign right_key = cell_key[i+1];
        end

        assign valid = (CNT_W'(i) < count_reg);

        sukt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .valid     (valid),
            .probe     (probe_reg),
            .left_lt   (left_lt),
            .left_key  (left_key),
            .right_key (right_key),
            .key_q     (cell_key[i]),
            .lt_q      (cell_lt[i]),
            .eq_q      (cell_eq[i])
        );
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign found         = found_reg;
    assign removed_value = removed_reg;
    assign entry_count   = entry_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("count above capacity");

    a_accept_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> state_reg == sukt_pkg::S_CMP)
        else $error("transfer not followed by compare");

    a_cmp_upd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sukt_pkg::S_CMP |=> state_reg == sukt_pkg::S_UPD)
        else $error("compare not followed by update");

    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.ins |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow count");

    a_upd_result: assert property (@(posedge clk) disable iff (!rst_n)
        upd_go |=> out_valid && state_reg == sukt_pkg::S_IDLE)
        else $error("update produced no result");
`endif

endmodule

`default_nettype wire

// ===== rtl/sukt_cell.sv =====
// ----------------------------------------------------------------------------
// sukt_cell
// One slot of the table: holds a key, compares it against the probe and
// shifts in a neighbor's key on insert or delete.
// ----------------------------------------------------------------------------
`default_nettype none

module sukt_cell (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire sukt_pkg::cell_ctrl_t         ctrl,
    input  wire logic                         valid,
    input  wire logic signed [sukt_pkg::KEY_W-1:0] probe,
    input  wire logic                         left_lt,
    input  wire logic signed [sukt_pkg::KEY_W-1:0] left_key,
    input  wire logic signed [sukt_pkg::KEY_W-1:0] right_key,
    output logic signed [sukt_pkg::KEY_W-1:0] key_q,
    output logic                              lt_q,
    output logic                              eq_q
);

    logic signed [sukt_pkg::KEY_W-1:0] key_reg;
    logic signed [sukt_pkg::KEY_W-1:0] key_next;
    logic                              lt_reg;
    logic                              eq_reg;

    always_comb
    begin
        key_next = key_reg;
        if (ctrl.ins && !lt_reg)
        begin
            key_next = left_lt ? probe : left_key;
        end
        else if (ctrl.del && !lt_reg)
        begin
            key_next = right_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg <= 1'b0;
            eq_reg <= 1'b0;
        end
        else if (ctrl.cmp)
        begin
            lt_reg <= valid && (key_reg < probe);
            eq_reg <= valid && (key_reg == probe);
        end
    end

    assign key_q = key_reg;
    assign lt_q  = lt_reg;
    assign eq_q  = eq_reg;

endmodule

`default_nettype wire
